// ===== sv/msr_pkg.sv =====
// Package with the shared types and constants of the median selector.
package msr_pkg;

  localparam int SAMPLE_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_KEY,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } msr_state_t;

endpackage

// ===== sv/msr_in_if.sv =====
// Input channel carrying one sample and its end-of-set flag per transfer.
interface msr_in_if;
  logic             valid;
  logic             ready;
  msr_pkg::sample_t sample;
  logic             last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== sv/msr_out_if.sv =====
// Output channel carrying the median result of one closed set per transfer.
interface msr_out_if;
  logic             valid;
  logic             ready;
  msr_pkg::sample_t median_value;
  logic             found;
  logic             overflow;

  modport source (output valid, output median_value, output found, output overflow,
                  input ready);
  modport sink   (input valid, input median_value, input found, input overflow,
                  output ready);
endinterface

// ===== sv/msr_store.sv =====
// Single-port-write, single-port-read sample memory with a registered read.
module msr_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  msr_pkg::sample_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output msr_pkg::sample_t rdata
);

  msr_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/median_select_by_rank_core.sv =====
// Top level of the median selector: sample loading, rank-count scan and result register.
//
//   Channel   Dir  Payload                          Transfer rule
//   samples   in   sample[31:0] signed, last        valid && ready
//   results   out  median_value[31:0] signed,       valid && ready
//                  found, overflow
//
// Loading takes one sample per cycle; samples.ready is high only while loading.
// An odd-sized set of n samples then goes through the rank scan: each candidate
// costs one read for its key and n reads for the comparison pass, and the single
// read port of the sample memory serializes them. Empty and even sets skip the scan.
// A result waits in the output register while results.ready is low. The next set
// starts loading as soon as a result enters that register, and its own result
// holds in the done state until the register is free. Synchronous reset clears
// the control state only.
module median_select_by_rank_core #(
  parameter int MAX_ITEMS = 256
) (
  input logic       clk,
  input logic       rst,
  msr_in_if.sink    samples,
  msr_out_if.source results
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  msr_pkg::msr_state_t state, state_next;

  logic [CW-1:0]    count;
  logic             ovf;
  logic [CW-1:0]    n;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    less;
  logic [CW-1:0]    more;
  msr_pkg::sample_t ki;
  logic             found_q;

  logic             out_valid;
  msr_pkg::sample_t out_median;
  logic             out_found;
  logic             out_ovf;

  logic             in_fire;
  logic             store_ok;
  logic [CW-1:0]    n_last;
  logic [CW-1:0]    half;
  logic             pass;
  logic             done_fire;

  logic             mem_we;
  logic             mem_re;
  logic [CW-1:0]    rd_idx;
  msr_pkg::sample_t rd_data;

  msr_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (samples.sample),
    .re    (mem_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  assign store_ok  = (count != CAP);
  assign in_fire   = samples.valid && samples.ready;
  assign n_last    = store_ok ? count + 1'b1 : count;
  assign half      = (n - 1'b1) >> 1;
  assign pass      = (less <= half) && (more <= half);
  assign done_fire = (state == msr_pkg::ST_DONE) && (!out_valid || results.ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      msr_pkg::ST_LOAD: begin
        if (in_fire && samples.last) begin
          if (n_last == '0 || !n_last[0]) begin
            state_next = msr_pkg::ST_DONE;
          end else begin
            state_next = msr_pkg::ST_FETCH;
          end
        end
      end
      msr_pkg::ST_FETCH: state_next = msr_pkg::ST_KEY;
      msr_pkg::ST_KEY:   state_next = msr_pkg::ST_SCAN;
      msr_pkg::ST_SCAN: begin
        if (j == n) begin
          state_next = msr_pkg::ST_DECIDE;
        end
      end
      msr_pkg::ST_DECIDE: begin
        if (pass || i == n - 1'b1) begin
          state_next = msr_pkg::ST_DONE;
        end else begin
          state_next = msr_pkg::ST_FETCH;
        end
      end
      msr_pkg::ST_DONE: begin
        if (done_fire) begin
          state_next = msr_pkg::ST_LOAD;
        end
      end
      default: state_next = msr_pkg::ST_LOAD;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    samples.ready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rd_idx        = j;
    case (state)
      msr_pkg::ST_LOAD: begin
        samples.ready = 1'b1;
        mem_we        = in_fire && store_ok;
      end
      msr_pkg::ST_FETCH: begin
        mem_re = 1'b1;
        rd_idx = i;
      end
      msr_pkg::ST_KEY, msr_pkg::ST_SCAN: begin
        mem_re = (j != n);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msr_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Load counters; they clear when the result is handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (done_fire) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (in_fire) begin
      if (store_ok) begin
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Rank scan: every scan cycle compares the word read in the previous cycle
  // against the candidate key, so each cycle of the pass carries one comparison.
  always_ff @(posedge clk) begin
    case (state)
      msr_pkg::ST_LOAD: begin
        n       <= n_last;
        i       <= '0;
        found_q <= 1'b0;
      end
      msr_pkg::ST_KEY: begin
        ki   <= rd_data;
        j    <= CW'(1);
        less <= '0;
        more <= '0;
      end
      msr_pkg::ST_SCAN: begin
        if (j != n) begin
          j <= j + 1'b1;
        end
        if (rd_data < ki) begin
          less <= less + 1'b1;
        end else if (rd_data > ki) begin
          more <= more + 1'b1;
        end
      end
      msr_pkg::ST_DECIDE: begin
        if (pass) begin
          found_q <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
      default: begin
        j <= '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !results.ready) || done_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_median <= found_q ? ki : '0;
      out_found  <= found_q;
      out_ovf    <= ovf;
    end
  end

  assign results.valid        = out_valid;
  assign results.median_value = out_median;
  assign results.found        = out_found;
  assign results.overflow     = out_ovf;

  // The fill count never passes the store capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("sample count exceeds store capacity");

  // A candidate is only fetched while it lies inside the closed set.
  a_fetch_range: assert property (@(posedge clk) disable iff (rst)
    (state == msr_pkg::ST_FETCH) |-> (i < n))
    else $error("candidate index beyond set size");

  // The decision is taken only after the full comparison pass.
  a_pass_done: assert property (@(posedge clk) disable iff (rst)
    (state == msr_pkg::ST_DECIDE) |-> (j == n && $past(state) == msr_pkg::ST_SCAN))
    else $error("decision before the comparison pass finished");

  // A result without a median carries a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.found) |-> (results.median_value == '0))
    else $error("nonzero median reported without found");

endmodule
